@@ src/lru_pkg.sv @@
`default_nettype none

package lru_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS = 10;
    localparam int TOTAL_W = 24;
    localparam int MEM_SIZE_W = 5;
    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int USED_W = $clog2(MAX_FRAMES + 1);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [USED_W-1:0] t_used;
    typedef logic [TOTAL_W-1:0] t_total;
    typedef logic [MEM_SIZE_W-1:0] t_mem_size;

    localparam t_mem_size MEM_SIZE_RESET = t_mem_size'(16);
    localparam t_total TOTAL_MAX = '1;

    typedef struct packed {
        logic hit;
        logic evict_valid;
        t_page evicted_page;
    } t_lookup;

endpackage

`default_nettype wire

@@ src/lru_req_if.sv @@
`default_nettype none

interface lru_req_if;

    logic valid;
    logic ready;
    lru_pkg::t_page page;
    logic start_run;

    modport source (output valid, output page, output start_run, input ready);
    modport sink (input valid, input page, input start_run, output ready);

endinterface

`default_nettype wire

@@ src/lru_rsp_if.sv @@
`default_nettype none

interface lru_rsp_if;

    logic valid;
    logic ready;
    logic hit;
    logic evict_valid;
    lru_pkg::t_page evicted_page;
    lru_pkg::t_total hit_total;
    lru_pkg::t_total miss_total;

    modport source (
        output valid, output hit, output evict_valid, output evicted_page,
        output hit_total, output miss_total, input ready
    );
    modport sink (
        input valid, input hit, input evict_valid, input evicted_page,
        input hit_total, input miss_total, output ready
    );

endinterface

`default_nettype wire

@@ src/lru_page_replacement.sv @@
// lru page replacement: fully associative, least recently used, up to 16 frames
//
// i_req carries one page access per item (page, start_run). start_run empties
// every frame and clears both totals before the access is looked up.
// o_rsp returns one item per access: hit, evict_valid, evicted_page and the
// saturating 24-bit hit and miss totals of the current run.
// i_cfg_we / i_cfg_wdata write mem_size (frames in use); 0 acts as 1 and
// values above 16 act as 16. write it only while no item is in flight.
//
// an accepted item sits in the input register, is looked up against all frames
// in parallel while it is held there and moves to the output register, which
// drives o_rsp, once that is empty or being read: one item per cycle sustained
// while o_rsp is not stalled. the single combinational lookup and rank update
// over the frame table sets the rate.
// while o_rsp is stalled one more item is taken into the input register, then
// i_req.ready drops until the output register is read.
// reset (synchronous, active low) empties the frames, clears the totals and
// sets mem_size to 16.
`default_nettype none

module lru_page_replacement (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire lru_pkg::t_mem_size  i_cfg_wdata,
    lru_req_if.sink                  i_req,
    lru_rsp_if.source                o_rsp
);
    import lru_pkg::*;

    t_mem_size r_mem_size;
    logic r_in_valid;
    t_page r_in_page;
    logic r_in_start;
    logic r_out_valid;
    t_lookup r_out_lookup;
    t_total r_out_hit_total;
    t_total r_out_miss_total;

    logic advance;
    t_used limit;
    t_lookup lookup;
    t_total hit_total_next;
    t_total miss_total_next;

    always_comb begin
        if (r_mem_size == '0) begin
            limit = t_used'(1);
        end else if (r_mem_size > MAX_FRAMES) begin
            limit = t_used'(MAX_FRAMES);
        end else begin
            limit = t_used'(r_mem_size);
        end
    end

    assign advance = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= MEM_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_mem_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_page <= i_req.page;
            r_in_start <= i_req.start_run;
        end
    end

    lru_frame_table u_frame_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_page      (r_in_page),
        .i_start_run (r_in_start),
        .i_limit     (limit),
        .o_lookup    (lookup)
    );

    lru_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_start_run  (r_in_start),
        .i_hit        (lookup.hit),
        .o_hit_total  (hit_total_next),
        .o_miss_total (miss_total_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_lookup <= lookup;
            r_out_hit_total <= hit_total_next;
            r_out_miss_total <= miss_total_next;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.hit = r_out_lookup.hit;
    assign o_rsp.evict_valid = r_out_lookup.evict_valid;
    assign o_rsp.evicted_page = r_out_lookup.evicted_page;
    assign o_rsp.hit_total = r_out_hit_total;
    assign o_rsp.miss_total = r_out_miss_total;

    ast_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> !(lookup.hit && lookup.evict_valid))
        else $error("hit and eviction on the same item");

    ast_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !lookup.evict_valid |-> lookup.evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    ast_new_run_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_start |->
            (lookup.hit && hit_total_next == t_total'(1) && miss_total_next == '0) ||
            (!lookup.hit && hit_total_next == '0 && miss_total_next == t_total'(1)))
        else $error("totals not restarted on new run");

    ast_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_out_hit_total)
            && $stable(r_out_miss_total))
        else $error("stalled item overwritten");

endmodule

`default_nettype wire

@@ src/lru_frame_table.sv @@
`default_nettype none

module lru_frame_table (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  wire lru_pkg::t_page i_page,
    input  wire                 i_start_run,
    input  wire lru_pkg::t_used i_limit,
    output lru_pkg::t_lookup    o_lookup
);
    import lru_pkg::*;

    t_page r_frame_page [MAX_FRAMES];
    t_rank r_rank [MAX_FRAMES];
    t_used r_used;

    t_rank n_rank [MAX_FRAMES];
    t_used n_used;
    t_used used_eff;
    t_rank oldest;
    t_rank hit_rank;
    t_page evicted;
    logic [MAX_FRAMES-1:0] in_use;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] victim;
    logic [MAX_FRAMES-1:0] target;
    logic hit;
    logic fill;

    always_comb begin
        used_eff = i_start_run ? '0 : r_used;
        oldest = t_rank'(used_eff - t_used'(1));
        hit_rank = '0;
        evicted = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            in_use[i] = t_used'(i) < used_eff;
            match[i] = in_use[i] && (r_frame_page[i] == i_page);
            victim[i] = in_use[i] && (r_rank[i] == oldest);
            hit_rank = hit_rank | (match[i] ? r_rank[i] : '0);
            evicted = evicted | (victim[i] ? r_frame_page[i] : '0);
        end
        hit = |match;
        fill = !hit && (used_eff < i_limit);
        n_used = fill ? used_eff + t_used'(1) : used_eff;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (hit) begin
                target[i] = match[i];
            end else if (fill) begin
                target[i] = t_used'(i) == used_eff;
            end else begin
                target[i] = victim[i];
            end
            if (target[i]) begin
                n_rank[i] = '0;
            end else if (in_use[i] && (!hit || r_rank[i] < hit_rank)) begin
                n_rank[i] = r_rank[i] + t_rank'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
        o_lookup.hit = hit;
        o_lookup.evict_valid = !hit && !fill;
        o_lookup.evicted_page = (!hit && !fill) ? evicted : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_advance) begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (target[i]) begin
                    r_frame_page[i] <= i_page;
                end
                r_rank[i] <= n_rank[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/lru_stats.sv @@
`default_nettype none

module lru_stats (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_advance,
    input  wire             i_start_run,
    input  wire             i_hit,
    output lru_pkg::t_total o_hit_total,
    output lru_pkg::t_total o_miss_total
);
    import lru_pkg::*;

    t_total r_hit_total;
    t_total r_miss_total;
    t_total n_hit_total;
    t_total n_miss_total;
    t_total hit_base;
    t_total miss_base;

    always_comb begin
        hit_base = i_start_run ? '0 : r_hit_total;
        miss_base = i_start_run ? '0 : r_miss_total;
        n_hit_total = (i_hit && hit_base != TOTAL_MAX) ? hit_base + t_total'(1) : hit_base;
        n_miss_total = (!i_hit && miss_base != TOTAL_MAX) ?
                       miss_base + t_total'(1) : miss_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_total <= '0;
            r_miss_total <= '0;
        end else if (i_advance) begin
            r_hit_total <= n_hit_total;
            r_miss_total <= n_miss_total;
        end
    end

    assign o_hit_total = n_hit_total;
    assign o_miss_total = n_miss_total;

endmodule

`default_nettype wire

@@ test/lru_page_replacement_test.sv @@
`timescale 1ns / 1ps

module lru_page_replacement_test;
    import lru_pkg::*;

    typedef struct {
        t_page page;
        logic  start_run;
    } t_access;

    typedef struct {
        logic   hit;
        logic   evict_valid;
        t_page  evicted_page;
        t_total hit_total;
        t_total miss_total;
    } t_access_result;

    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD = 64;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 93;
    localparam int SETTLE_CYCLES = 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    t_mem_size i_cfg_wdata = MEM_SIZE_RESET;

    lru_req_if req_bus ();
    lru_rsp_if rsp_bus ();

    lru_page_replacement i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    t_access pending_items[$];
    t_access_result predicted_lookups[$];

    // predicted frame table
    t_page frame_pg [MAX_FRAMES];
    int rank_of [MAX_FRAMES];
    int used_frames = 0;
    int hit_count = 0;
    int miss_count = 0;
    int mem_size_now = MEM_SIZE_RESET;

    bit no_idle = 1'b0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int evictions_seen = 0;

    always #6 i_clk = ~i_clk;

    // age every used frame more recent than old_rank, then make idx most recent
    function automatic void make_recent(int idx, int old_rank);
        for (int i = 0; i < used_frames; i++) begin
            if (i != idx && rank_of[i] < old_rank) begin
                rank_of[i]++;
            end
        end
        rank_of[idx] = 0;
    endfunction

    function automatic t_access_result lru_lookup(t_access acc);
        t_access_result r;
        int found;
        int limit;
        int victim;
        r = '{hit: 1'b0, evict_valid: 1'b0, evicted_page: '0, hit_total: '0, miss_total: '0};
        found = -1;
        if (acc.start_run) begin
            used_frames = 0;
            hit_count = 0;
            miss_count = 0;
        end
        limit = (mem_size_now < 1) ? 1 : ((mem_size_now > MAX_FRAMES) ? MAX_FRAMES : mem_size_now);
        for (int i = 0; i < used_frames; i++) begin
            if (found < 0 && frame_pg[i] == acc.page) begin
                found = i;
            end
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            make_recent(found, rank_of[found]);
            if (hit_count < int'(TOTAL_MAX)) begin
                hit_count++;
            end
        end else begin
            if (used_frames < limit) begin
                frame_pg[used_frames] = acc.page;
                used_frames++;
                make_recent(used_frames - 1, MAX_FRAMES + 1);
            end else begin
                victim = 0;
                for (int i = used_frames - 1; i >= 0; i--) begin
                    if (rank_of[i] == used_frames - 1) begin
                        victim = i;
                    end
                end
                r.evict_valid = 1'b1;
                r.evicted_page = frame_pg[victim];
                frame_pg[victim] = acc.page;
                make_recent(victim, rank_of[victim]);
            end
            if (miss_count < int'(TOTAL_MAX)) begin
                miss_count++;
            end
        end
        r.hit_total = t_total'(hit_count);
        r.miss_total = t_total'(miss_count);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_access next_access;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_bus.page <= '0;
            req_bus.start_run <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                predicted_lookups.insert(predicted_lookups.size(),
                                         lru_lookup('{req_bus.page, req_bus.start_run}));
                items_sent++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 35)) begin
                    next_access = pending_items[0];
                    pending_items.delete(0);
                    req_bus.valid <= 1'b1;
                    req_bus.page <= next_access.page;
                    req_bus.start_run <= next_access.start_run;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_access_result exp_r;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (predicted_lookups.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual hit %0b evict %0b page %0d",
                             $time, rsp_bus.hit, rsp_bus.evict_valid, rsp_bus.evicted_page);
                end else begin
                    exp_r = predicted_lookups[0];
                    predicted_lookups.delete(0);
                    check_field("hit", exp_r.hit, rsp_bus.hit);
                    check_field("evict_valid", exp_r.evict_valid, rsp_bus.evict_valid);
                    check_field("evicted_page", exp_r.evicted_page, rsp_bus.evicted_page);
                    check_field("hit_total", exp_r.hit_total, rsp_bus.hit_total);
                    check_field("miss_total", exp_r.miss_total, rsp_bus.miss_total);
                    results_seen++;
                    hits_seen += exp_r.hit;
                    evictions_seen += exp_r.evict_valid;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (holds_started != hold_requests) begin
                holds_started++;
                hold_left = LONG_HOLD;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= no_idle || ($urandom_range(99) >= 35);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_access(int page, logic start_run);
        pending_items.insert(pending_items.size(), '{t_page'(page), start_run});
    endtask

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || req_bus.valid || predicted_lookups.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mem_size(int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= t_mem_size'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mem_size_now = value;
    endtask

    initial begin
        int mem_plan [PHASES];
        int pool [$];
        int pool_size;
        int page;
        logic start_run;
        mem_plan = '{16, 1, 0, 31, 3, 16, 7, 2, 0, 0};
        mem_plan[8] = $urandom_range(31);
        mem_plan[9] = $urandom_range(31);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // page extremes with the reset frame count
        add_access(0, 1'b1);
        add_access(1023, 1'b0);
        add_access(0, 1'b0);
        add_access(1023, 1'b0);
        add_access(512, 1'b0);
        add_access(0, 1'b0);
        drain();
        // single frame, back to back evictions
        write_mem_size(1);
        add_access(5, 1'b1);
        add_access(5, 1'b0);
        add_access(6, 1'b0);
        add_access(7, 1'b0);
        drain();
        // zero frames acts as one
        write_mem_size(0);
        add_access(1023, 1'b1);
        add_access(0, 1'b0);
        add_access(0, 1'b0);
        drain();
        // above the frame count saturates
        write_mem_size(31);
        add_access(20, 1'b1);
        add_access(21, 1'b0);
        drain();
        // limit lowered then raised within one run
        write_mem_size(3);
        add_access(1, 1'b1);
        add_access(2, 1'b0);
        add_access(3, 1'b0);
        drain();
        write_mem_size(1);
        add_access(4, 1'b0);
        add_access(2, 1'b0);
        drain();
        write_mem_size(5);
        add_access(9, 1'b0);
        drain();

        // random phases over a small working set with some stray pages
        for (int p = 0; p < PHASES; p++) begin
            write_mem_size(mem_plan[p]);
            pool_size = $urandom_range(1, 24);
            pool.delete();
            for (int i = 0; i < pool_size; i++) begin
                pool.insert(pool.size(), $urandom_range(1023));
            end
            no_idle = (p == 2);
            if (p == 5) begin
                hold_requests++;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                start_run = (n == 0 && p % 3 == 0) || ($urandom_range(99) < 3);
                if ($urandom_range(99) < 85) begin
                    page = pool[$urandom_range(pool_size - 1)];
                end else begin
                    page = $urandom_range(1023);
                end
                add_access(page, start_run);
            end
            drain();
        end
        no_idle = 1'b0;

        $display("%0d page accesses sent, %0d results checked: %0d hits, %0d evictions",
                 items_sent, results_seen, hits_seen, evictions_seen);
        $display("frame limits 0 to 31 with mid-run changes, a long output stall and a full-rate run");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
